### hw/rtl/rpn_eval_pkg.sv
// ----------------------------------------------------------------------------
// rpn_eval_pkg
// Shared widths, command and status codes for the postfix evaluator.
// ----------------------------------------------------------------------------
package rpn_eval_pkg;

  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int DEPTH_OUT_W = 5;
  localparam int STATUS_W    = 2;
  localparam int ITER_W      = $clog2(DATA_W);
  localparam int StackDepthDefault = 16;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

endpackage

### hw/rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix evaluator over a bounded stack of signed 32-bit operands.
// ----------------------------------------------------------------------------
// Each token gives one result item (top of stack, depth, status). The top of
// the stack lives in a register and the entries below it in a RAM, so an
// operator needs one RAM read for its left operand. All arithmetic runs
// through one shared 33-bit adder under a small sequencer: multiply is
// shift-add, one multiplier bit a cycle, and divide is restoring, one
// quotient bit a cycle, plus sign fix-ups on the same adder. The input is
// stalled until the current token is finished; a finished result waits in
// the output register while the next token is taken.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = rpn_eval_pkg::StackDepthDefault
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [rpn_eval_pkg::CMD_W-1:0]           in_command,
  input  logic signed [rpn_eval_pkg::DATA_W-1:0]   in_number,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [rpn_eval_pkg::DATA_W-1:0]   out_top_value,
  output logic [rpn_eval_pkg::DEPTH_OUT_W-1:0]     out_depth,
  output logic [rpn_eval_pkg::STATUS_W-1:0]        out_status
);

  import rpn_eval_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_READ = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_NEGN = 9'b000001000,
    S_NEGD = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_NEGQ = 9'b001000000,
    S_WB   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [DATA_W-1:0]   tos_r, tos_nxt;
  logic [CMD_W-1:0]    op_r, op_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]   den_r, den_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic                neg_n_r, neg_n_nxt;
  logic                neg_d_r, neg_d_nxt;
  logic                neg_q_r, neg_q_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_top_r, out_top_nxt;
  logic [DEPTH_OUT_W-1:0] out_depth_r, out_depth_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic [DATA_W:0]     add_a, add_b, add_sum;
  logic                add_sub;
  logic [DATA_W:0]     rem_sh;
  logic                in_accept;
  logic                out_free;

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tos_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign ram_waddr = AW'(count_r - CW'(1));
  assign ram_raddr = AW'(count_r - CW'(2));
  assign rem_sh    = {rem_r, quo_r[DATA_W-1]};

  // shared adder
  assign add_sum = add_a + (add_b ^ {(DATA_W+1){add_sub}}) + (DATA_W+1)'(add_sub);

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_READ: begin
        add_a   = {1'b0, ram_rdata};
        add_b   = {1'b0, tos_r};
        add_sub = (op_r == CMD_SUB);
      end
      S_MUL: begin
        add_a = {1'b0, acc_r};
        add_b = {1'b0, den_r};
      end
      S_NEGN: begin
        add_b   = {1'b0, quo_r};
        add_sub = 1'b1;
      end
      S_NEGD: begin
        add_b   = {1'b0, den_r};
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = rem_sh;
        add_b   = {1'b0, den_r};
        add_sub = 1'b1;
      end
      S_NEGQ: begin
        add_b   = {1'b0, quo_r};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    tos_nxt        = tos_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    quo_nxt        = quo_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    acc_nxt        = acc_r;
    iter_nxt       = iter_r;
    neg_n_nxt      = neg_n_r;
    neg_d_nxt      = neg_d_r;
    neg_q_nxt      = neg_q_r;
    ram_we         = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt     = in_command;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          unique case (in_command) inside
            CMD_PUSH: begin
              if (count_r == CW'(STACK_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = (count_r != '0);
                tos_nxt   = in_number;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (count_r < CW'(2)) begin
                status_nxt = ST_FEW;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        iter_nxt = '0;
        unique case (op_r) inside
          CMD_ADD, CMD_SUB: begin
            tos_nxt   = add_sum[DATA_W-1:0];
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end
          CMD_MUL: begin
            acc_nxt   = '0;
            den_nxt   = ram_rdata;
            quo_nxt   = tos_r;
            state_nxt = S_MUL;
          end
          default: begin
            if (tos_r == '0) begin
              status_nxt = ST_DIVZERO;
              state_nxt  = S_DONE;
            end else begin
              quo_nxt   = ram_rdata;
              den_nxt   = tos_r;
              neg_n_nxt = ram_rdata[DATA_W-1];
              neg_d_nxt = tos_r[DATA_W-1];
              neg_q_nxt = ram_rdata[DATA_W-1] ^ tos_r[DATA_W-1];
              state_nxt = S_NEGN;
            end
          end
        endcase
      end
      S_MUL: begin
        if (quo_r[0]) begin
          acc_nxt = add_sum[DATA_W-1:0];
        end
        quo_nxt  = quo_r >> 1;
        den_nxt  = den_r << 1;
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == '1) begin
          state_nxt = S_WB;
        end
      end
      S_NEGN: begin
        if (neg_n_r) begin
          quo_nxt = add_sum[DATA_W-1:0];
        end
        state_nxt = S_NEGD;
      end
      S_NEGD: begin
        if (neg_d_r) begin
          den_nxt = add_sum[DATA_W-1:0];
        end
        rem_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!add_sum[DATA_W]) begin
          rem_nxt = add_sum[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == '1) begin
          state_nxt = S_NEGQ;
        end
      end
      S_NEGQ: begin
        acc_nxt   = neg_q_r ? add_sum[DATA_W-1:0] : quo_r;
        state_nxt = S_WB;
      end
      S_WB: begin
        tos_nxt   = acc_r;
        count_nxt = count_r - CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_top_nxt    = (count_r != '0) ? tos_r : '0;
          out_depth_nxt  = DEPTH_OUT_W'(count_r);
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    quo_r        <= quo_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    acc_r        <= acc_nxt;
    iter_r       <= iter_nxt;
    neg_n_r      <= neg_n_nxt;
    neg_d_r      <= neg_d_nxt;
    neg_q_r      <= neg_q_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_status    = out_status_r;

endmodule

### hw/rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the postfix evaluator. A short table of tokens walks through
// the operand extremes, every command, wraparound, too few operands, a full
// stack, divide by zero and the unused codes. About 900 random tokens follow,
// biased by the predicted stack depth so that the stack fills and drains
// often. A shadow stack predicts each result item, and the items that come
// out are checked in order, field by field. Sender and receiver idle at
// random in two of three phases; in the third neither idles.
// ----------------------------------------------------------------------------
module tb_top;
  import rpn_eval_pkg::*;

  localparam int STACK_DEPTH     = StackDepthDefault;
  localparam int ITEMS_PER_PHASE = 303;
  localparam int TAIL_CYCLES     = 80;
  localparam int CYCLE_LIMIT     = 600_000;

  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct {
    logic signed [DATA_W-1:0]  top;
    logic [DEPTH_OUT_W-1:0]    depth;
    logic [STATUS_W-1:0]       status;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [DATA_W-1:0]  num;
    int                        reps;
    bit                        typed;
    result_t                   res;
  } token_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CMD_W-1:0]            in_command = '0;
  logic signed [DATA_W-1:0]    in_number = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [DATA_W-1:0]    out_top_value;
  logic [DEPTH_OUT_W-1:0]      out_depth;
  logic [STATUS_W-1:0]         out_status;

  logic [DATA_W-1:0]           shadow_stack [STACK_DEPTH];
  int                          shadow_count = 0;
  result_t                     pending_results [$];
  token_row_t                  token_table [$];
  int                          send_idle_pct = 27;
  int                          recv_idle_pct = 75;
  int                          mismatches = 0;
  int                          cycle_count = 0;

  postfix_expression_evaluator #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_top_value (out_top_value),
    .out_depth     (out_depth),
    .out_status    (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t evaluate_token(input logic [CMD_W-1:0] cmd,
                                             input logic [DATA_W-1:0] num);
    result_t           r;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] mag_l;
    logic [DATA_W-1:0] mag_r;
    logic [DATA_W-1:0] quo;
    logic [STATUS_W-1:0] st;
    bit                commit;
    st = ST_OK;
    commit = 1'b0;
    res = '0;
    if (cmd == CMD_PUSH) begin
      if (shadow_count >= STACK_DEPTH) begin
        st = ST_FULL;
      end else begin
        shadow_stack[shadow_count] = num;
        shadow_count++;
      end
    end else if (cmd <= CMD_DIV) begin
      if (shadow_count < 2) begin
        st = ST_FEW;
      end else begin
        rhs = shadow_stack[shadow_count-1];
        lhs = shadow_stack[shadow_count-2];
        commit = 1'b1;
        case (cmd)
          CMD_ADD: res = lhs + rhs;
          CMD_SUB: res = lhs - rhs;
          CMD_MUL: res = lhs * rhs;
          default: begin
            if (rhs == '0) begin
              commit = 1'b0;
              st = ST_DIVZERO;
            end else begin
              // divide magnitudes, then fix the sign; truncates toward zero
              mag_l = lhs[DATA_W-1] ? -lhs : lhs;
              mag_r = rhs[DATA_W-1] ? -rhs : rhs;
              quo = mag_l / mag_r;
              res = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
            end
          end
        endcase
        if (commit) begin
          shadow_count--;
          shadow_stack[shadow_count-1] = res;
        end
      end
    end
    r.top = (shadow_count > 0) ? shadow_stack[shadow_count-1] : '0;
    r.depth = shadow_count[DEPTH_OUT_W-1:0];
    r.status = st;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] num,
                         input int reps, input bit typed,
                         input logic [DATA_W-1:0] top, input int depth,
                         input logic [STATUS_W-1:0] status);
    token_row_t row;
    row.cmd = cmd;
    row.num = num;
    row.reps = reps;
    row.typed = typed;
    row.res.top = top;
    row.res.depth = depth[DEPTH_OUT_W-1:0];
    row.res.status = status;
    token_table.insert(token_table.size(), row);
  endtask

  task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] num,
                            input bit typed, input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_number <= num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = evaluate_token(cmd, num);
    if (typed) begin
      pending_results.insert(pending_results.size(), typed_res);
    end else begin
      pending_results.insert(pending_results.size(), predicted);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result side: check every accepted item, then pick the next stall
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected item", out_top_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_top_value !== want.top)
          note_mismatch("top_value", out_top_value, want.top);
        if (out_depth !== want.depth)
          note_mismatch("depth", DATA_W'(out_depth), DATA_W'(want.depth));
        if (out_status !== want.status)
          note_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    token_row_t        row;
    result_t           none;
    logic [CMD_W-1:0]  cmd;
    logic [CMD_W-1:0]  op;
    logic [DATA_W-1:0] num;
    int                pick;
    int                push_pct;
    none = '{default: '0};
    push_pct = 50;

    //      command    number        reps typed top           depth status
    add_row(CMD_ADD,   32'h0,        1,   1'b1, 32'h0,        0,  ST_FEW);
    add_row(CMD_DIV,   32'h0,        1,   1'b1, 32'h0,        0,  ST_FEW);
    add_row(CMD_RSVD7, 32'h7fffffff, 1,   1'b1, 32'h0,        0,  ST_OK);
    add_row(CMD_PUSH,  32'h7fffffff, 1,   1'b1, 32'h7fffffff, 1,  ST_OK);
    add_row(CMD_SUB,   32'h0,        1,   1'b1, 32'h7fffffff, 1,  ST_FEW);
    add_row(CMD_PUSH,  32'h1,        1,   1'b1, 32'h1,        2,  ST_OK);
    add_row(CMD_ADD,   32'hffffffff, 1,   1'b1, 32'h80000000, 1,  ST_OK);
    add_row(CMD_PUSH,  32'hffffffff, 1,   1'b1, 32'hffffffff, 2,  ST_OK);
    add_row(CMD_DIV,   32'h0,        1,   1'b1, 32'h80000000, 1,  ST_OK);
    add_row(CMD_PUSH,  32'h0,        1,   1'b1, 32'h0,        2,  ST_OK);
    add_row(CMD_DIV,   32'h0,        1,   1'b1, 32'h0,        2,  ST_DIVZERO);
    add_row(CMD_RSVD5, 32'h80000000, 1,   1'b1, 32'h0,        2,  ST_OK);
    add_row(CMD_MUL,   32'h0,        1,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_PUSH,  32'hfffffff9, 1,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_PUSH,  32'h2,        1,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_DIV,   32'h0,        1,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_SUB,   32'h0,        1,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_RSVD6, 32'h5a5a5a5a, 1,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_PUSH,  32'h80000000, 1,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_MUL,   32'h0,        1,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_PUSH,  32'h12345678, 15,  1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_PUSH,  32'h0,        1,   1'b1, 32'h12345678, 16, ST_FULL);
    add_row(CMD_MUL,   32'h0,        3,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_PUSH,  32'h7fffffff, 2,   1'b0, 32'h0,        0,  ST_OK);
    add_row(CMD_MUL,   32'h0,        1,   1'b0, 32'h0,        0,  ST_OK);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (token_table[i]) begin
      row = token_table[i];
      repeat (row.reps) send_token(row.cmd, row.num, row.typed, row.res);
    end
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 27; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // let the push share drift so the stack both fills and empties
        if (n % 40 == 0) push_pct = $urandom_range(75, 30);
        pick = $urandom_range(99);
        op = 3'($urandom_range(CMD_DIV, CMD_ADD));
        if (shadow_count < 2) begin
          cmd = (pick < 85) ? CMD_PUSH : op;
        end else if (shadow_count >= STACK_DEPTH) begin
          cmd = (pick < 15) ? CMD_PUSH : op;
        end else if (pick < 5) begin
          cmd = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
        end else begin
          cmd = (pick < 5 + push_pct) ? CMD_PUSH : op;
        end
        pick = $urandom_range(99);
        if (pick < 30) begin
          num = 32'($urandom_range(40)) - 32'd20;
        end else if (pick < 45) begin
          case ($urandom_range(4))
            0: num = 32'h0;
            1: num = 32'h1;
            2: num = 32'hffffffff;
            3: num = 32'h7fffffff;
            default: num = 32'h80000000;
          endcase
        end else begin
          num = $urandom;
        end
        send_token(cmd, num, 1'b0, none);
        if ($urandom_range(199) == 0) drain_results();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rpn_eval_pkg.sv
hw/rtl/rpn_ram.sv
hw/rtl/postfix_expression_evaluator.sv
dv/tb_top.sv
